>>> src/first_fit_arena_allocator_top_defines.svh
// Assertion macros used by the allocator's controller.
// FFA_ASSERT_IMPL checks that the consequent holds in the same cycle as the antecedent.
// FFA_ASSERT_NEXT checks that the consequent holds in the cycle after the antecedent.
`ifndef FIRST_FIT_ARENA_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define FFA_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define FFA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define FFA_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define FFA_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> src/ffa_pkg.sv
package ffa_pkg;

    localparam int ARENA_BYTES = 1024;
    localparam int MAX_BLOCKS  = 32;

    localparam int SIZE_W   = 10;
    localparam int HANDLE_W = 10;
    localparam int OFF_W    = 10;
    localparam int HDR_W    = 7;
    localparam int STATUS_W = 2;

    localparam int START_W = $clog2(ARENA_BYTES);
    localparam int LEN_W   = $clog2(ARENA_BYTES + 1);
    localparam int NEED_W  = ((SIZE_W > HDR_W) ? SIZE_W : HDR_W) + 1;
    localparam int ALU_W   = ((LEN_W > NEED_W) ? LEN_W : NEED_W) + 1;
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);

    localparam logic [HDR_W-1:0] HDR_RESET = HDR_W'(40);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } ffa_status_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } ffa_kind_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } ffa_alu_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NEED,
        S_RD,
        S_CHK,
        S_SPLIT,
        S_UP_RD,
        S_UP_WR,
        S_UP_FIN,
        S_SPLIT_WR,
        S_TOP,
        S_TOPCHK,
        S_NX_RD,
        S_NX_CHK,
        S_MRG1,
        S_MRG2,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } ffa_state_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               used;
    } ffa_entry_t;

    typedef struct packed {
        ffa_kind_t             kind;
        logic [SIZE_W-1:0]     size;
        logic [HANDLE_W-1:0]   handle;
    } ffa_item_t;

    typedef struct packed {
        ffa_status_t        status;
        logic [OFF_W-1:0]   offset;
    } ffa_res_t;

    typedef struct packed {
        ffa_alu_op_t        op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } ffa_alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0]   res;
        logic               zero;
        logic               borrow;
    } ffa_alu_rsp_t;

endpackage

>>> src/ffa_ram.sv
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/ffa_alu.sv
module ffa_alu (
    input  ffa_pkg::ffa_alu_req_t req,
    output ffa_pkg::ffa_alu_rsp_t rsp
);

    import ffa_pkg::*;

    logic [ALU_W:0] wide;

    // One adder/subtractor; the extra top bit is the borrow of a subtraction.
    always_comb
    begin
        case (req.op)
            ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
            default: wide = '0;
        endcase
        rsp.res    = wide[ALU_W-1:0];
        rsp.zero   = (wide[ALU_W-1:0] == '0);
        rsp.borrow = (req.op == ALU_SUB) && wide[ALU_W];
    end

endmodule

>>> src/ffa_ctrl.sv
`include "first_fit_arena_allocator_top_defines.svh"

module ffa_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  ffa_pkg::ffa_item_t          item,
    input  logic [ffa_pkg::HDR_W-1:0]   hdr,
    input  logic                        res_take,
    output logic                        idle,
    output logic                        res_valid,
    output ffa_pkg::ffa_res_t           res
);

    import ffa_pkg::*;

    ffa_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  top_reg, top_next;

    ffa_item_t         item_reg, item_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [1:0]        gap_reg, gap_next;
    ffa_entry_t        cur_reg, cur_next;
    ffa_entry_t        prev_reg, prev_next;
    ffa_entry_t        nxt_reg, nxt_next;
    logic              nfree_reg, nfree_next;
    logic [ALU_W-1:0]  tmp_reg, tmp_next;
    ffa_status_t       st_reg, st_next;
    logic [OFF_W-1:0]  off_reg, off_next;

    ffa_alu_req_t alu_req;
    ffa_alu_rsp_t alu_rsp;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    ffa_entry_t                  ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [$bits(ffa_entry_t)-1:0] ram_rdata;
    ffa_entry_t                  rd_ent;

    logic [CNT_W-1:0] idx_p1;
    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] k_m1;
    logic [CNT_W-1:0] k_mgap;
    logic             prev_free;

    ffa_ram #(
        .WIDTH($bits(ffa_entry_t)),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffa_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign rd_ent    = ffa_entry_t'(ram_rdata);
    assign idx_p1    = idx_reg + CNT_W'(1);
    assign idx_m1    = idx_reg - CNT_W'(1);
    assign k_m1      = k_reg - CNT_W'(1);
    assign k_mgap    = k_reg - CNT_W'(gap_reg);
    assign prev_free = (idx_reg != '0) && !prev_reg.used;

    assign idle       = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = st_reg;
    assign res.offset = off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            top_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        need_reg  <= need_next;
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        gap_reg   <= gap_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        nxt_reg   <= nxt_next;
        nfree_reg <= nfree_next;
        tmp_reg   <= tmp_next;
        st_reg    <= st_next;
        off_reg   <= off_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        top_next   = top_reg;
        item_next  = item_reg;
        need_next  = need_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        gap_next   = gap_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        nxt_next   = nxt_reg;
        nfree_next = nfree_reg;
        tmp_next   = tmp_reg;
        st_next    = st_reg;
        off_next   = off_reg;

        alu_req.op = ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;

        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = '0;
        ram_raddr = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_NEED;
                end
            end

            S_NEED:
            begin
                // A request of zero total bytes still takes one byte.
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(item_reg.size);
                alu_req.b  = ALU_W'(hdr);
                need_next  = alu_rsp.zero ? NEED_W'(1) : alu_rsp.res[NEED_W-1:0];
                idx_next   = '0;
                state_next = S_RD;
            end

            S_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (item_reg.kind == KIND_ALLOC)
                    begin
                        state_next = S_TOP;
                    end
                    else
                    begin
                        st_next    = ST_BAD_HANDLE;
                        off_next   = '0;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ram_raddr  = idx_reg[IDX_W-1:0];
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                if (item_reg.kind == KIND_ALLOC)
                begin
                    alu_req.op = ALU_SUB;
                    alu_req.a  = ALU_W'(rd_ent.len);
                    alu_req.b  = ALU_W'(need_reg);
                    if (!rd_ent.used && !alu_rsp.borrow)
                    begin
                        cur_next = rd_ent;
                        tmp_next = alu_rsp.res;
                        if (!alu_rsp.zero && (cnt_reg < CNT_W'(MAX_BLOCKS)))
                        begin
                            state_next = S_SPLIT;
                        end
                        else
                        begin
                            // Exact fit, or no entry left for a remainder.
                            ram_we     = 1'b1;
                            ram_waddr  = idx_reg[IDX_W-1:0];
                            ram_wdata  = '{start: rd_ent.start, len: rd_ent.len, used: 1'b1};
                            st_next    = ST_OK;
                            off_next   = OFF_W'(rd_ent.start);
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_p1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    alu_req.op = ALU_SUB;
                    alu_req.a  = ALU_W'(rd_ent.start);
                    alu_req.b  = ALU_W'(item_reg.handle);
                    if (alu_rsp.zero)
                    begin
                        if (!rd_ent.used)
                        begin
                            st_next    = ST_BAD_HANDLE;
                            off_next   = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cur_next   = rd_ent;
                            state_next = S_NX_RD;
                        end
                    end
                    else
                    begin
                        prev_next  = rd_ent;
                        idx_next   = idx_p1;
                        state_next = S_RD;
                    end
                end
            end

            S_SPLIT:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(cur_reg.start);
                alu_req.b  = ALU_W'(need_reg);
                nxt_next   = '{start: START_W'(alu_rsp.res), len: LEN_W'(tmp_reg), used: 1'b0};
                k_next     = cnt_reg;
                state_next = S_UP_RD;
            end

            S_UP_RD:
            begin
                if (k_reg == idx_p1)
                begin
                    state_next = S_UP_FIN;
                end
                else
                begin
                    ram_raddr  = k_m1[IDX_W-1:0];
                    state_next = S_UP_WR;
                end
            end

            S_UP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg[IDX_W-1:0];
                ram_wdata  = rd_ent;
                k_next     = k_m1;
                state_next = S_UP_RD;
            end

            S_UP_FIN:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_p1[IDX_W-1:0];
                ram_wdata  = nxt_reg;
                state_next = S_SPLIT_WR;
            end

            S_SPLIT_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IDX_W-1:0];
                ram_wdata  = '{start: cur_reg.start, len: LEN_W'(need_reg), used: 1'b1};
                cnt_next   = cnt_reg + CNT_W'(1);
                st_next    = ST_OK;
                off_next   = OFF_W'(cur_reg.start);
                state_next = S_DONE;
            end

            S_TOP:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(top_reg);
                alu_req.b  = ALU_W'(need_reg);
                tmp_next   = alu_rsp.res;
                state_next = S_TOPCHK;
            end

            S_TOPCHK:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_W'(ARENA_BYTES);
                alu_req.b  = tmp_reg;
                if (alu_rsp.borrow)
                begin
                    st_next  = ST_NO_SPACE;
                    off_next = '0;
                end
                else if (cnt_reg >= CNT_W'(MAX_BLOCKS))
                begin
                    st_next  = ST_TABLE_FULL;
                    off_next = '0;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[IDX_W-1:0];
                    ram_wdata = '{start: START_W'(top_reg), len: LEN_W'(need_reg), used: 1'b1};
                    cnt_next  = cnt_reg + CNT_W'(1);
                    top_next  = LEN_W'(tmp_reg);
                    st_next   = ST_OK;
                    off_next  = OFF_W'(top_reg);
                end
                state_next = S_DONE;
            end

            S_NX_RD:
            begin
                if (idx_p1 < cnt_reg)
                begin
                    ram_raddr  = idx_p1[IDX_W-1:0];
                    state_next = S_NX_CHK;
                end
                else
                begin
                    nfree_next = 1'b0;
                    state_next = S_MRG1;
                end
            end

            S_NX_CHK:
            begin
                nxt_next   = rd_ent;
                nfree_next = !rd_ent.used;
                state_next = S_MRG1;
            end

            S_MRG1:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(cur_reg.len);
                alu_req.b  = nfree_reg ? ALU_W'(nxt_reg.len) : '0;
                tmp_next   = alu_rsp.res;
                state_next = S_MRG2;
            end

            S_MRG2:
            begin
                ram_we = 1'b1;
                if (prev_free)
                begin
                    alu_req.op = ALU_ADD;
                    alu_req.a  = ALU_W'(prev_reg.len);
                    alu_req.b  = tmp_reg;
                    ram_waddr  = idx_m1[IDX_W-1:0];
                    ram_wdata  = '{start: prev_reg.start, len: LEN_W'(alu_rsp.res), used: 1'b0};
                end
                else
                begin
                    ram_waddr = idx_reg[IDX_W-1:0];
                    ram_wdata = '{start: cur_reg.start, len: LEN_W'(tmp_reg), used: 1'b0};
                end
                // Entries after the merged ones close up over the dropped entries.
                gap_next   = {1'b0, nfree_reg} + {1'b0, prev_free};
                k_next     = idx_p1 + CNT_W'(nfree_reg);
                st_next    = ST_OK;
                off_next   = OFF_W'(item_reg.handle);
                state_next = (nfree_reg || prev_free) ? S_DN_RD : S_DONE;
            end

            S_DN_RD:
            begin
                if (k_reg == cnt_reg)
                begin
                    cnt_next   = cnt_reg - CNT_W'(gap_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = k_reg[IDX_W-1:0];
                    state_next = S_DN_WR;
                end
            end

            S_DN_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = k_mgap[IDX_W-1:0];
                ram_wdata  = rd_ent;
                k_next     = k_reg + CNT_W'(1);
                state_next = S_DN_RD;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `FFA_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(MAX_BLOCKS))
    `FFA_ASSERT_IMPL(a_top_bound, clk, rst_n, 1'b1, top_reg <= LEN_W'(ARENA_BYTES))
    `FFA_ASSERT_NEXT(a_start_runs, clk, rst_n, start, state_reg == S_NEED)
    `FFA_ASSERT_IMPL(a_err_off_zero, clk, rst_n, res_valid && (st_reg != ST_OK), off_reg == '0)
    `FFA_ASSERT_NEXT(a_idle_holds, clk, rst_n, idle && !start, cnt_reg == $past(cnt_reg))

endmodule

>>> src/first_fit_arena_allocator_top.sv
// Channel  | Handshake            | Beat fields
// ---------+----------------------+---------------------------------
// cfg      | cfg_wr_en            | cfg_wr_data (header_bytes)
// in       | in_valid / in_stall  | kind, size, handle
// out      | out_valid / out_stall| status, offset
//
// An allocate beat reads table entries one at a time and moves the entries after the fit
// up on a split; a free beat is alike, with entries moved down on a merge. Entries scanned
// and entries moved never add up to more than the table, and the next beat is taken only
// once the sequencer is back in idle. The pace is set by the single read port of the block
// table RAM (registered read data) and the one shared adder/subtractor.
// Reset clears the block count, the arena top and the header size to 40; the table RAM is
// not cleared, since only entries below the block count are ever read.
// in_stall is high from the accepted request until its result has been moved into the
// output register; a waiting result in that register does not hold back the next request.

module first_fit_arena_allocator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ffa_pkg::HDR_W-1:0]      cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           kind,
    input  logic [ffa_pkg::SIZE_W-1:0]     size,
    input  logic [ffa_pkg::HANDLE_W-1:0]   handle,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ffa_pkg::STATUS_W-1:0]   status,
    output logic [ffa_pkg::OFF_W-1:0]      offset
);

    import ffa_pkg::*;

    logic [HDR_W-1:0]    hdr_reg;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [OFF_W-1:0]    offset_reg;

    logic       idle;
    logic       start;
    logic       res_valid;
    logic       res_take;
    ffa_item_t  item;
    ffa_res_t   res;

    // The sequencer only takes a request while it sits idle.
    assign in_stall = !idle;
    assign start    = in_valid && idle;

    assign item.kind   = ffa_kind_t'(kind);
    assign item.size   = size;
    assign item.handle = handle;

    // A finished result moves into the output register once that register is empty
    // or its beat is being taken in the same cycle.
    assign res_take       = res_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = res_take || (out_valid_reg && out_stall);

    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .hdr       (hdr_reg),
        .res_take  (res_take),
        .idle      (idle),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg       <= HDR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                hdr_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Output beat payload; it only changes when a new result is loaded.
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            status_reg <= res.status;
            offset_reg <= res.offset;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign offset    = offset_reg;

endmodule

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    // Cycles to let pass before a header write, after the last result has come back.
    // A request walks the table entry by entry and may shift every entry once.
    localparam int DRAIN_CYCLES = 4 * MAX_BLOCKS + 32;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [HDR_W-1:0] cfg_wr_data;
    logic in_valid;
    logic in_stall;
    logic kind;
    logic [SIZE_W-1:0] size;
    logic [HANDLE_W-1:0] handle;
    logic out_valid;
    logic out_stall;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0] offset;

    // Shadow copy of the allocator: the address-ordered block table, the number of
    // live entries, the end of the last block and the current header size.
    ffa_entry_t arena_map [MAX_BLOCKS];
    int block_count;
    int arena_top;
    logic [HDR_W-1:0] header_bytes;

    // Results that the allocator still owes, oldest first.
    ffa_res_t pending_results[$];

    int errors;
    int alloc_requests;
    int free_requests;
    int header_settings;
    int outcome_count [4];

    // Knobs that the test tasks turn. The sender leaves gaps between bursts when
    // gaps_on is set; the receiver stalls in runs whose length grows with stall_mode.
    // A nonzero hold_request asks the receiver for a single long hold of that length.
    bit gaps_on;
    int stall_mode;
    int hold_request;
    int burst_left;

    first_fit_arena_allocator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .size        (size),
        .handle      (handle),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .offset      (offset)
    );

    always #2 clk = ~clk;

    // Removes one entry from the shadow table and closes the hole it leaves.
    function automatic void drop_span(input int idx);
        for (int k = idx; k + 1 < block_count; k++)
            arena_map[k] = arena_map[k + 1];
        block_count--;
    endfunction

    // First fit: the lowest free block that is long enough is taken. A longer block
    // is split unless the table has no room for the remainder. With no fit, a new
    // block goes on top of the arena, and the space check comes before the table check.
    function automatic ffa_res_t allocate_block(input int req);
        int need;
        ffa_res_t r;
        need = req + int'(header_bytes);
        if (need == 0)
            need = 1;
        r.status = ST_OK;
        r.offset = '0;
        for (int i = 0; i < block_count; i++)
        begin
            if (!arena_map[i].used && int'(arena_map[i].len) >= need)
            begin
                if (int'(arena_map[i].len) > need && block_count < MAX_BLOCKS)
                begin
                    for (int k = block_count; k > i + 1; k--)
                        arena_map[k] = arena_map[k - 1];
                    arena_map[i + 1].start = START_W'(int'(arena_map[i].start) + need);
                    arena_map[i + 1].len = LEN_W'(int'(arena_map[i].len) - need);
                    arena_map[i + 1].used = 1'b0;
                    arena_map[i].len = LEN_W'(need);
                    block_count++;
                end
                arena_map[i].used = 1'b1;
                r.offset = OFF_W'(arena_map[i].start);
                return r;
            end
        end
        if (arena_top + need > ARENA_BYTES)
            r.status = ST_NO_SPACE;
        else if (block_count >= MAX_BLOCKS)
            r.status = ST_TABLE_FULL;
        else
        begin
            arena_map[block_count].start = START_W'(arena_top);
            arena_map[block_count].len = LEN_W'(need);
            arena_map[block_count].used = 1'b1;
            block_count++;
            r.offset = OFF_W'(arena_top);
            arena_top += need;
        end
        return r;
    endfunction

    // A free names a used block by its start. The block is merged with a free
    // successor first and then with a free predecessor. The top never comes down.
    function automatic ffa_res_t release_block(input int start);
        int idx;
        ffa_res_t r;
        idx = -1;
        r.status = ST_BAD_HANDLE;
        r.offset = '0;
        for (int i = 0; i < block_count; i++)
        begin
            if (idx < 0 && int'(arena_map[i].start) == start)
                idx = i;
        end
        if (idx < 0 || !arena_map[idx].used)
            return r;
        arena_map[idx].used = 1'b0;
        if (idx + 1 < block_count && !arena_map[idx + 1].used)
        begin
            arena_map[idx].len = arena_map[idx].len + arena_map[idx + 1].len;
            drop_span(idx + 1);
        end
        if (idx > 0 && !arena_map[idx - 1].used)
        begin
            arena_map[idx - 1].len = arena_map[idx - 1].len + arena_map[idx].len;
            drop_span(idx);
        end
        r.status = ST_OK;
        r.offset = OFF_W'(start);
        return r;
    endfunction

    // Offers one request beat and holds it until the allocator takes it. With gaps_on set,
    // bursts of random length are separated by random gaps, now and then long ones, so that
    // a new beat can show up at any point of the allocator's work. The expected
    // result is worked out at the edge that accepts the beat.
    task automatic send_request(input ffa_kind_t k, input logic [SIZE_W-1:0] sz,
                                input logic [HANDLE_W-1:0] h);
        int gap;
        ffa_res_t outcome;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            if (gaps_on)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                  : $urandom_range(0, 4);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k;
        size <= sz;
        handle <= h;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (k == KIND_ALLOC)
        begin
            outcome = allocate_block(int'(sz));
            alloc_requests++;
        end
        else
        begin
            outcome = release_block(int'(h));
            free_requests++;
        end
        outcome_count[outcome.status]++;
        pending_results.push_back(outcome);
    endtask

    // The header register may only change while the allocator is idle, so the input
    // is parked, every owed result is collected and the allocator is given time to
    // settle before the write.
    task automatic write_header(input logic [HDR_W-1:0] value);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        header_bytes = value;
        header_settings++;
    endtask

    // Frees every used block in a random order, which exercises merges on both sides
    // and leaves the table as one large free block below the top.
    task automatic release_all();
        int live[$];
        int pick;
        for (int i = 0; i < block_count; i++)
            if (arena_map[i].used)
                live.push_back(int'(arena_map[i].start));
        while (live.size() != 0)
        begin
            pick = $urandom_range(0, live.size() - 1);
            send_request(KIND_FREE, SIZE_W'($urandom), HANDLE_W'(live[pick]));
            live.delete(pick);
        end
    endtask

    // One random request. Most traffic is well formed: allocations of modest size and
    // frees of blocks that are in use. The rest is noise: huge sizes, frees of random
    // offsets and frees of blocks that are already free.
    task automatic random_request(input int big_pct);
        int live[$];
        int idle[$];
        int roll;
        for (int i = 0; i < block_count; i++)
        begin
            if (arena_map[i].used)
                live.push_back(int'(arena_map[i].start));
            else
                idle.push_back(int'(arena_map[i].start));
        end
        roll = $urandom_range(0, 99);
        if (roll < 5)
            send_request(KIND_FREE, SIZE_W'($urandom), HANDLE_W'($urandom));
        else if (roll < 8 && idle.size() != 0)
            send_request(KIND_FREE, SIZE_W'($urandom),
                         HANDLE_W'(idle[$urandom_range(0, idle.size() - 1)]));
        else if (roll < 50 && live.size() != 0)
            send_request(KIND_FREE, SIZE_W'($urandom),
                         HANDLE_W'(live[$urandom_range(0, live.size() - 1)]));
        else if ($urandom_range(0, 99) < big_pct)
            send_request(KIND_ALLOC, SIZE_W'($urandom), HANDLE_W'($urandom));
        else
            send_request(KIND_ALLOC, SIZE_W'($urandom_range(0, 48)), HANDLE_W'($urandom));
    endtask

    task automatic random_phase(input logic [HDR_W-1:0] hdr, input int count,
                                input int big_pct, input bit gaps, input int stalls);
        write_header(hdr);
        gaps_on = gaps;
        stall_mode = stalls;
        repeat (count) random_request(big_pct);
    endtask

    // Straight from reset with the default header of 40 bytes: a free against an empty
    // table, a request too big for the arena, appends, a split, an exact fit, a double
    // free, the release of the very first block and merges on either side.
    task automatic test_directed_basics();
        gaps_on = 1'b0;
        stall_mode = 0;
        send_request(KIND_FREE, '0, '0);
        send_request(KIND_ALLOC, '0, '1);
        send_request(KIND_ALLOC, '1, '0);
        send_request(KIND_FREE, '1, '1);
        send_request(KIND_ALLOC, 10'd100, '0);
        send_request(KIND_ALLOC, 10'd60, '0);
        send_request(KIND_FREE, '0, 10'd40);
        send_request(KIND_FREE, '0, 10'd40);
        send_request(KIND_ALLOC, 10'd20, '0);
        send_request(KIND_ALLOC, 10'd40, '0);
        send_request(KIND_FREE, '0, 10'd0);
        send_request(KIND_FREE, '0, 10'd180);
        send_request(KIND_FREE, '0, 10'd100);
        send_request(KIND_FREE, '0, 10'd40);
    endtask

    // A header of zero makes a zero-byte request take a single byte. The widest header
    // pushes a full-size request past the arena, while a request of the right size
    // takes the whole free block as an exact fit.
    task automatic test_header_extremes();
        write_header('0);
        send_request(KIND_ALLOC, '0, '0);
        send_request(KIND_ALLOC, '0, '0);
        send_request(KIND_FREE, '0, 10'd1);
        send_request(KIND_FREE, '0, 10'd0);
        write_header('1);
        send_request(KIND_ALLOC, '1, '0);
        send_request(KIND_ALLOC, 10'd153, '0);
        send_request(KIND_FREE, '0, 10'd0);
        send_request(KIND_ALLOC, '0, '0);
        send_request(KIND_FREE, '0, 10'd0);
    endtask

    // Tiny blocks split the free space until the table runs out of entries. The next
    // fit is then handed out whole, and appends fail with the table full while the
    // arena still has room.
    task automatic test_table_fill();
        write_header(7'd1);
        gaps_on = 1'b1;
        stall_mode = 1;
        repeat (40) send_request(KIND_ALLOC, SIZE_W'($urandom_range(0, 3)), HANDLE_W'($urandom));
        release_all();
    endtask

    // Mixed traffic under several header sizes and idling patterns, including one
    // stretch where neither side ever idles.
    task automatic test_random_traffic();
        random_phase(7'd40, 110, 4, 1'b1, 1);
        random_phase(HDR_W'($urandom_range(2, 126)), 110, 6, 1'b1, 3);
        random_phase(7'd0, 110, 3, 1'b0, 0);
        release_all();
        random_phase(7'd127, 90, 10, 1'b1, 2);
        random_phase(7'd64, 100, 5, 1'b1, 1);
        random_phase(HDR_W'($urandom_range(0, 127)), 60, 8, 1'b0, 3);
    endtask

    // The receiver holds off for a long time while the sender keeps offering beats
    // back to back, so the output register fills and the input stalls.
    task automatic test_output_hold();
        gaps_on = 1'b0;
        stall_mode = 0;
        hold_request = 400;
        repeat (12) random_request(4);
    endtask

    // Receiver: alternating runs of stall and no stall, their lengths drawn at random,
    // or a single long hold when a test asks for one.
    initial
    begin
        int run;
        int hold_left;
        bit level;
        out_stall = 1'b0;
        run = 0;
        hold_left = 0;
        level = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_mode == 0)
                out_stall <= 1'b0;
            else
            begin
                if (run == 0)
                begin
                    level = ~level;
                    run = level ? $urandom_range(1, 4 * stall_mode) : $urandom_range(1, 6);
                end
                run--;
                out_stall <= level;
            end
        end
    end

    // Every result beat is matched against the oldest result still owed.
    always @(posedge clk)
    begin
        ffa_res_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: status %0d offset %0d", status, offset);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    errors++;
                end
                if (offset !== want.offset)
                begin
                    $error("offset mismatch: expected %0d, actual %0d", want.offset, offset);
                    errors++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        kind = 1'b0;
        size = '0;
        handle = '0;
        block_count = 0;
        arena_top = 0;
        header_bytes = HDR_RESET;
        errors = 0;
        alloc_requests = 0;
        free_requests = 0;
        header_settings = 0;
        outcome_count = '{default: 0};
        gaps_on = 1'b0;
        stall_mode = 0;
        hold_request = 0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_header_extremes();
        test_table_fill();
        test_output_hold();
        test_random_traffic();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests (%0d allocate, %0d free) under %0d header writes.",
                 alloc_requests + free_requests, alloc_requests, free_requests,
                 header_settings);
        $display("Outcomes: %0d ok, %0d no space, %0d table full, %0d bad handle.",
                 outcome_count[ST_OK], outcome_count[ST_NO_SPACE],
                 outcome_count[ST_TABLE_FULL], outcome_count[ST_BAD_HANDLE]);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
